### rtl/core/assert_macros.svh
// Assertion macros used by the deque RTL.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/cad_pkg.sv
// Shared types and codes for the circular array deque.
// No dependencies.
package cad_pkg;

  localparam int unsigned WORD_W = 32;

  // request codes
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_REAR   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } cad_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } cad_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } cad_stat_t;

endpackage

### rtl/core/cad_ctrl.sv
// Sequencer for the deque: take a word, execute it, hand off the result.
// Depends on cad_pkg.
module cad_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cad_pkg::cad_stat_t stat,
  output cad_pkg::cad_cmd_t  cmd
);
  import cad_pkg::*;

  cad_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/cad_datapath.sv
// Deque datapath: entry memory, front/rear pointers, empty flag, result register.
// Depends on cad_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cad_datapath #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cad_pkg::cad_cmd_t           cmd,
  output cad_pkg::cad_stat_t          stat,
  input  logic [1:0]                  req_type,
  input  logic signed [31:0]          push_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          pop_value,
  output logic [1:0]                  status,
  output logic                        now_empty,
  output logic                        now_full
);
  import cad_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ZERO = '0;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [1:0]        req_q;
  logic [WORD_W-1:0] value_q;
  logic [AW-1:0]     front, front_next;
  logic [AW-1:0]     rear, rear_next;
  logic              empty_q, empty_next;
  logic              pop_ok;
  logic [1:0]        status_q;
  logic [WORD_W-1:0] rd_data;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              is_push, full, last;
  logic [1:0]        res_status;
  logic [AW-1:0]     front_dec, rear_inc, front_inc, rear_dec;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? ZERO : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == ZERO) ? LAST : p - AW'(1);
  endfunction

  assign front_dec = wrap_dec(front);
  assign front_inc = wrap_inc(front);
  assign rear_inc  = wrap_inc(rear);
  assign rear_dec  = wrap_dec(rear);
  assign full      = !empty_q && (rear_inc == front);
  assign last      = (front == rear);
  assign is_push   = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_REAR);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    empty_next = empty_q;
    wr_en      = 1'b0;
    wr_addr    = ZERO;
    rd_en      = 1'b0;
    rd_addr    = front;
    res_status = ST_DONE;
    if (is_push) begin
      if (full) begin
        res_status = ST_OVERFLOW;
      end else begin
        wr_en = 1'b1;
        if (empty_q) begin
          front_next = ZERO;
          rear_next  = ZERO;
          empty_next = 1'b0;
          wr_addr    = ZERO;
        end else if (req_q == REQ_PUSH_FRONT) begin
          front_next = front_dec;
          wr_addr    = front_dec;
        end else begin
          rear_next = rear_inc;
          wr_addr   = rear_inc;
        end
      end
    end else begin
      if (empty_q) begin
        res_status = ST_UNDERFLOW;
      end else begin
        rd_en   = 1'b1;
        rd_addr = (req_q == REQ_POP_FRONT) ? front : rear;
        if (last) begin
          front_next = ZERO;
          rear_next  = ZERO;
          empty_next = 1'b1;
        end else if (req_q == REQ_POP_FRONT) begin
          front_next = front_inc;
        end else begin
          rear_next = rear_dec;
        end
      end
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= ZERO;
      rear    <= ZERO;
      empty_q <= 1'b1;
    end else if (cmd.exec) begin
      front   <= front_next;
      rear    <= rear_next;
      empty_q <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q   <= req_type;
      value_q <= push_value;
    end
    if (cmd.exec) begin
      pop_ok   <= rd_en;
      status_q <= res_status;
    end
  end

  // result register; flags come from the state already updated
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pop_value <= pop_ok ? rd_data : '0;
      status    <= status_q;
      now_empty <= empty_q;
      now_full  <= full;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  `ASSERT_CLK(a_empty_ptrs_home, empty_q |-> (front == ZERO && rear == ZERO),
              "empty deque with pointers away from slot 0")
  `ASSERT_CLK(a_ovf_full, (out_valid && status == ST_OVERFLOW) |-> now_full,
              "overflow reported while not full")
  `ASSERT_CLK(a_unf_empty, (out_valid && status == ST_UNDERFLOW) |-> now_empty,
              "underflow reported while not empty")
  `ASSERT_CLK(a_flags_excl, out_valid |-> !(now_empty && now_full),
              "result flags both empty and full")
  `ASSERT_CLK(a_load_free, cmd.load_out |-> (!out_valid || out_ready),
              "result loaded over a word not yet taken")

endmodule

### rtl/core/circular_array_deque_unit.sv
// Top level of the circular array deque: controller plus datapath.
// Depends on cad_pkg, cad_ctrl and cad_datapath.
//
//   channel  direction  handshake             fields
//   in       into       in_valid / in_ready   req_type, push_value
//   out      out of     out_valid / out_ready pop_value, status, now_empty, now_full
//
// Each word is accepted, executed (at most one memory access and the
// pointer update), then loaded into the result register. Pops read
// the entry memory's registered read port in the execute step.
// A held result register stalls the load step until out_ready frees it.
// Reset empties the deque at once; memory contents are not cleared.
module circular_array_deque_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pop_value,
  output logic [1:0]         status,
  output logic               now_empty,
  output logic               now_full
);
  import cad_pkg::*;

  cad_cmd_t  cmd;
  cad_stat_t stat;

  cad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cad_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pop_value  (pop_value),
    .status     (status),
    .now_empty  (now_empty),
    .now_full   (now_full)
  );

endmodule
